>>> hw/rtl/gpm_pkg.sv
// Shared types, constants and helpers for the gradient position mapper.
package gpm_pkg;

  localparam int DEF_PIXEL_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int KIND_W   = 3;
  localparam int COORD_W  = 20;
  localparam int DELTA_W  = COORD_W + 1;
  localparam int LEN_W    = 2 * DELTA_W;
  localparam int CFG_IDX_W = 3;

  localparam int ANGLE_W        = 64;
  localparam int TURN_W         = 32;
  localparam int ANGLE_STEPS    = 32;
  localparam int ANGLE_NORM_MSB = 59;
  // prep stage, two normalize stages, one stage per rotation
  localparam int ANG_LAT        = ANGLE_STEPS + 3;

  localparam logic [KIND_W-1:0] KIND_LINEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RADIAL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ANGLE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REFLECTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIAMOND   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;

  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_3QUARTER = 32'hC000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } gpm_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              degenerate;
  } gpm_ctl_t;

  // width of the signed point-minus-start value
  function automatic int rel_w(int pixel_bits);
    int px_w;
    px_w = pixel_bits + 4;
    return ((px_w > COORD_W - 1) ? px_w : COORD_W - 1) + 2;
  endfunction

  // width of the signed dot and cross products
  function automatic int dot_w(int pixel_bits);
    return rel_w(pixel_bits) + DELTA_W + 1;
  endfunction

  function automatic int max_i(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // arctangent of 2^-i in turns, 2^32 is one turn
  function automatic logic [TURN_W-1:0] atan_turn(int i);
    logic [TURN_W-1:0] v;
    unique case (i)
      0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
      3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
      6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
      9: v = 32'd1335087;   10: v = 32'd667544;    11: v = 32'd333772;
      12: v = 32'd166886;   13: v = 32'd83443;     14: v = 32'd41722;
      15: v = 32'd20861;    16: v = 32'd10430;     17: v = 32'd5215;
      18: v = 32'd2608;     19: v = 32'd1304;      20: v = 32'd652;
      21: v = 32'd326;      22: v = 32'd163;       23: v = 32'd81;
      24: v = 32'd41;       25: v = 32'd20;        26: v = 32'd10;
      27: v = 32'd5;        28: v = 32'd3;         29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/gpm_if.sv
// Request channel interfaces for pixel coordinates and gradient positions.
interface gpm_in_if #(parameter int PIXEL_BITS = gpm_pkg::DEF_PIXEL_BITS) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gpm_out_if #(parameter int POSITION_FRAC_BITS = gpm_pkg::DEF_FRAC_BITS) ();
  logic                        valid;
  logic                        ready;
  logic [POSITION_FRAC_BITS:0] position;
  logic                        degenerate;
  modport source (output valid, output position, output degenerate, input ready);
  modport sink (input valid, input position, input degenerate, output ready);
endinterface

>>> hw/rtl/gpm_delay.sv
// Enable-gated delay line that aligns the result lanes.
module gpm_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  if (DEPTH == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [WIDTH-1:0] tap_r [DEPTH];

    // advance the line on each pipeline step
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= din;
        for (int i = 1; i < DEPTH; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end

    assign dout = tap_r[DEPTH-1];
  end

endmodule

>>> hw/rtl/gpm_front.sv
// Front stages: relative point, products, dot/cross/lengths, lane operand setup.
module gpm_front #(
  parameter int PIXEL_BITS = gpm_pkg::DEF_PIXEL_BITS,
  localparam int DW = gpm_pkg::dot_w(PIXEL_BITS)
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [PIXEL_BITS-1:0]           pixel_x,
  input  logic [PIXEL_BITS-1:0]           pixel_y,
  input  gpm_pkg::gpm_cfg_t               cfg,
  output gpm_pkg::gpm_ctl_t               ctl_o,
  output logic [gpm_pkg::LEN_W-1:0]       len2_o,
  output logic [gpm_pkg::LEN_W:0]         rat_num_o,
  output logic [1:0]                      rat_tag_o,
  output logic [gpm_pkg::LEN_W:0]         rad_num_o,
  output logic                            rad_sat_o,
  output logic signed [DW-1:0]            ang_a_o,
  output logic signed [DW-1:0]            ang_b_o
);
  import gpm_pkg::*;

  localparam int PX_W = PIXEL_BITS + 4;
  localparam int RW   = rel_w(PIXEL_BITS);
  localparam int PW   = RW + DELTA_W;
  localparam int SQW  = 2 * DELTA_W;
  localparam int R2W  = 2 * RW;
  localparam int MW   = DW + 1;

  // stage 1: pixel centre relative to start, gradient vector
  logic [PX_W-1:0]           px, py;
  logic signed [RW-1:0]      rx_r, ry_r;
  logic signed [DELTA_W-1:0] dx1_r, dy1_r;
  gpm_ctl_t                  ctl1_r;

  // centre sits half a pixel in, eight sixteenths
  assign px = {pixel_x, 4'b1000};
  assign py = {pixel_y, 4'b1000};

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= $signed({{(RW-PX_W){1'b0}}, px})
             - $signed({{(RW-COORD_W){cfg.start_x[COORD_W-1]}}, cfg.start_x});
      ry_r  <= $signed({{(RW-PX_W){1'b0}}, py})
             - $signed({{(RW-COORD_W){cfg.start_y[COORD_W-1]}}, cfg.start_y});
      dx1_r <= $signed({cfg.end_x[COORD_W-1], cfg.end_x})
             - $signed({cfg.start_x[COORD_W-1], cfg.start_x});
      dy1_r <= $signed({cfg.end_y[COORD_W-1], cfg.end_y})
             - $signed({cfg.start_y[COORD_W-1], cfg.start_y});
      ctl1_r.kind       <= cfg.kind;
      ctl1_r.degenerate <= (cfg.end_x == cfg.start_x) && (cfg.end_y == cfg.start_y);
    end
  end

  // stage 2: all products
  logic signed [PW-1:0]      rxdx_r, rydy_r, rydx_r, rxdy_r;
  logic signed [SQW-1:0]     dxdx_r, dydy_r;
  logic signed [R2W-1:0]     rxrx_r, ryry_r;
  logic signed [DELTA_W-1:0] dx2_r, dy2_r;
  gpm_ctl_t                  ctl2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rxdx_r <= rx_r * dx1_r;
      rydy_r <= ry_r * dy1_r;
      rydx_r <= ry_r * dx1_r;
      rxdy_r <= rx_r * dy1_r;
      dxdx_r <= dx1_r * dx1_r;
      dydy_r <= dy1_r * dy1_r;
      rxrx_r <= rx_r * rx_r;
      ryry_r <= ry_r * ry_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      ctl2_r <= ctl1_r;
    end
  end

  // stage 3: dot, cross and squared lengths
  logic signed [DW-1:0]      dot_r, cross_r;
  logic [LEN_W-1:0]          len2_r;
  logic [R2W-1:0]            r2_r;
  logic signed [DELTA_W-1:0] dx3_r, dy3_r;
  gpm_ctl_t                  ctl3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r   <= $signed({rxdx_r[PW-1], rxdx_r}) + $signed({rydy_r[PW-1], rydy_r});
      cross_r <= $signed({rydx_r[PW-1], rydx_r}) - $signed({rxdy_r[PW-1], rxdy_r});
      len2_r  <= $unsigned(dxdx_r) + $unsigned(dydy_r);
      r2_r    <= $unsigned(rxrx_r) + $unsigned(ryry_r);
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      ctl3_r  <= ctl2_r;
    end
  end

  // stage 4: choose numerators, saturation flags and angle vector
  logic [DW-1:0]        abs_dot, abs_cross;
  logic [MW-1:0]        mag;
  logic                 sat_zero, sat_one, on_start;
  logic signed [DW-1:0] ang_a_nxt, ang_b_nxt;
  logic [R2W:0]         r2_x;

  // one spare top bit so the radial numerator slice always exists
  assign r2_x = {1'b0, r2_r};

  always_comb begin
    abs_dot   = dot_r[DW-1] ? $unsigned(-dot_r) : $unsigned(dot_r);
    abs_cross = cross_r[DW-1] ? $unsigned(-cross_r) : $unsigned(cross_r);
    mag       = '0;
    sat_zero  = 1'b1;
    unique case (ctl3_r.kind)
      KIND_LINEAR: begin
        mag      = {1'b0, $unsigned(dot_r)};
        sat_zero = dot_r[DW-1] || (dot_r == '0);
      end
      KIND_REFLECTED: begin
        mag      = {1'b0, abs_dot};
        sat_zero = (mag == '0);
      end
      KIND_DIAMOND: begin
        mag      = {1'b0, abs_dot} + {1'b0, abs_cross};
        sat_zero = (mag == '0);
      end
      default: begin
        mag      = '0;
        sat_zero = 1'b1;
      end
    endcase
    sat_one = !sat_zero && (mag >= {{(MW-LEN_W){1'b0}}, len2_r});

    // centre on the start point: use the gradient vector (dx, -dy) as the angle vector
    on_start  = (dot_r == '0) && (cross_r == '0);
    ang_a_nxt = on_start ? $signed({{(DW-DELTA_W){dx3_r[DELTA_W-1]}}, dx3_r}) : dot_r;
    ang_b_nxt = on_start ? -$signed({{(DW-DELTA_W){dy3_r[DELTA_W-1]}}, dy3_r}) : cross_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o     <= ctl3_r;
      len2_o    <= len2_r;
      rat_num_o <= mag[LEN_W:0];
      rat_tag_o <= {sat_one, sat_zero};
      rad_num_o <= r2_x[LEN_W:0];
      rad_sat_o <= (r2_r >= R2W'(len2_r));
      ang_a_o   <= ang_a_nxt;
      ang_b_o   <= ang_b_nxt;
    end
  end

endmodule

>>> hw/rtl/gpm_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
module gpm_div #(
  parameter int STEPS = gpm_pkg::DEF_FRAC_BITS,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [gpm_pkg::LEN_W:0]   num,
  input  logic [gpm_pkg::LEN_W-1:0] den,
  input  logic [TAG_W-1:0]          tag_in,
  output logic [STEPS-1:0]          quot,
  output logic [TAG_W-1:0]          tag_out
);
  import gpm_pkg::*;

  logic [LEN_W:0]   rem_r [STEPS];
  logic [LEN_W-1:0] den_r [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];
  logic [TAG_W-1:0] tag_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [LEN_W:0]   rem_p;
    logic [LEN_W-1:0] den_p;
    logic [STEPS-1:0] q_p;
    logic [TAG_W-1:0] tag_p;
    logic [LEN_W+1:0] rem2, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_p = num;
      assign den_p = den;
      assign q_p   = '0;
      assign tag_p = tag_in;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign q_p   = q_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    // shift in a zero, subtract the divisor where it fits
    assign rem2 = {rem_p, 1'b0};
    assign diff = rem2 - {2'b00, den_p};
    assign ge   = (rem2 >= {2'b00, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[LEN_W:0] : rem2[LEN_W:0];
        den_r[k] <= den_p;
        q_r[k]   <= {q_p[STEPS-2:0], ge};
        tag_r[k] <= tag_p;
      end
    end
  end

  assign quot    = q_r[STEPS-1];
  assign tag_out = tag_r[STEPS-1];

endmodule

>>> hw/rtl/gpm_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module gpm_sqrt #(
  parameter int ROOT_BITS = gpm_pkg::DEF_FRAC_BITS,
  parameter int TAG_W     = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*ROOT_BITS-1:0]   radicand,
  input  logic [TAG_W-1:0]         tag_in,
  output logic [ROOT_BITS-1:0]     root,
  output logic [TAG_W-1:0]         tag_out
);

  localparam int VW  = 2 * ROOT_BITS;
  localparam int RMW = ROOT_BITS + 2;

  logic [VW-1:0]        v_r    [ROOT_BITS];
  logic [RMW-1:0]       rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [TAG_W-1:0]     tag_r  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic [VW-1:0]        v_p;
    logic [RMW-1:0]       rem_p, rem_c, trial;
    logic [ROOT_BITS-1:0] root_p;
    logic [TAG_W-1:0]     tag_p;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_p    = radicand;
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = tag_in;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign tag_p  = tag_r[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_c = {rem_p[RMW-3:0], v_p[VW-1:VW-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (rem_c >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= {v_p[VW-3:0], 2'b00};
        rem_r[k]  <= ge ? (rem_c - trial) : rem_c;
        root_r[k] <= {root_p[ROOT_BITS-2:0], ge};
        tag_r[k]  <= tag_p;
      end
    end
  end

  assign root    = root_r[ROOT_BITS-1];
  assign tag_out = tag_r[ROOT_BITS-1];

endmodule

>>> hw/rtl/gpm_cordic.sv
// Angle lane: quadrant fold, normalize, 32-stage CORDIC vectoring in turns.
module gpm_cordic #(
  parameter int IN_W = gpm_pkg::dot_w(gpm_pkg::DEF_PIXEL_BITS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [IN_W-1:0]       a_in,
  input  logic signed [IN_W-1:0]       b_in,
  output logic [gpm_pkg::TURN_W-1:0]   turns
);
  import gpm_pkg::*;

  // prep stage: axis cases and fold into the right half plane
  logic signed [ANGLE_W-1:0] a_x, b_x, a_f, b_f;
  logic [ANGLE_W-1:0]        m_f;
  logic                      spec_f;
  logic [TURN_W-1:0]         specz_f, z_f;

  logic signed [ANGLE_W-1:0] pa_r, pb_r;
  logic [ANGLE_W-1:0]        pm_r;
  logic                      psp_r;
  logic [TURN_W-1:0]         psz_r, pz_r;

  always_comb begin
    a_x     = $signed({{(ANGLE_W-IN_W){a_in[IN_W-1]}}, a_in});
    b_x     = $signed({{(ANGLE_W-IN_W){b_in[IN_W-1]}}, b_in});
    a_f     = a_x;
    b_f     = b_x;
    spec_f  = 1'b0;
    specz_f = '0;
    z_f     = '0;
    priority if (b_x == '0) begin
      spec_f  = 1'b1;
      specz_f = a_x[ANGLE_W-1] ? TURN_HALF : '0;
    end else if (a_x == '0) begin
      spec_f  = 1'b1;
      specz_f = b_x[ANGLE_W-1] ? TURN_3QUARTER : TURN_QUARTER;
    end else if (a_x[ANGLE_W-1]) begin
      a_f = -a_x;
      b_f = -b_x;
      z_f = TURN_HALF;
    end else begin
      z_f = '0;
    end
    m_f = $unsigned(a_f) | (b_f[ANGLE_W-1] ? $unsigned(-b_f) : $unsigned(b_f));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= a_f;
      pb_r  <= b_f;
      pm_r  <= m_f;
      psp_r <= spec_f;
      psz_r <= specz_f;
      pz_r  <= z_f;
    end
  end

  // normalize stage 1: coarse shifts of 32, 16 and 8
  logic signed [ANGLE_W-1:0] n1a, n1b;
  logic [ANGLE_W-1:0]        n1m;
  logic signed [ANGLE_W-1:0] na_r, nb_r;
  logic [ANGLE_W-1:0]        nm_r;
  logic                      nsp_r;
  logic [TURN_W-1:0]         nsz_r, nz_r;

  always_comb begin
    n1a = pa_r;
    n1b = pb_r;
    n1m = pm_r;
    for (int j = 0; j < 3; j++) begin
      if ((n1m >> (ANGLE_NORM_MSB + 1 - (32 >> j))) == '0) begin
        n1a = n1a <<< (32 >> j);
        n1b = n1b <<< (32 >> j);
        n1m = n1m << (32 >> j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r  <= n1a;
      nb_r  <= n1b;
      nm_r  <= n1m;
      nsp_r <= psp_r;
      nsz_r <= psz_r;
      nz_r  <= pz_r;
    end
  end

  // normalize stage 2: fine shifts of 4, 2 and 1
  logic signed [ANGLE_W-1:0] n2a, n2b;
  logic [ANGLE_W-1:0]        n2m;

  logic signed [ANGLE_W-1:0] ca_r [ANGLE_STEPS+1];
  logic signed [ANGLE_W-1:0] cb_r [ANGLE_STEPS+1];
  logic [TURN_W-1:0]         cz_r [ANGLE_STEPS+1];
  logic                      csp_r [ANGLE_STEPS+1];
  logic [TURN_W-1:0]         csz_r [ANGLE_STEPS+1];

  always_comb begin
    n2a = na_r;
    n2b = nb_r;
    n2m = nm_r;
    for (int j = 0; j < 3; j++) begin
      if ((n2m >> (ANGLE_NORM_MSB + 1 - (4 >> j))) == '0) begin
        n2a = n2a <<< (4 >> j);
        n2b = n2b <<< (4 >> j);
        n2m = n2m << (4 >> j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r[0]  <= n2a;
      cb_r[0]  <= n2b;
      cz_r[0]  <= nz_r;
      csp_r[0] <= nsp_r;
      csz_r[0] <= nsz_r;
    end
  end

  // rotation stages: drive b toward zero, accumulate the angle
  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_rot
    logic signed [ANGLE_W-1:0] ta, tb;
    assign ta = ca_r[i] >>> i;
    assign tb = cb_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cb_r[i][ANGLE_W-1]) begin
          ca_r[i+1] <= ca_r[i] + tb;
          cb_r[i+1] <= cb_r[i] - ta;
          cz_r[i+1] <= cz_r[i] + atan_turn(i);
        end else begin
          ca_r[i+1] <= ca_r[i] - tb;
          cb_r[i+1] <= cb_r[i] + ta;
          cz_r[i+1] <= cz_r[i] - atan_turn(i);
        end
        csp_r[i+1] <= csp_r[i];
        csz_r[i+1] <= csz_r[i];
      end
    end
  end

  assign turns = csp_r[ANGLE_STEPS] ? csz_r[ANGLE_STEPS] : cz_r[ANGLE_STEPS];

endmodule

>>> hw/rtl/gradient_position_mapper_core.sv
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The radial lane (divider plus square root) or the CORDIC lane sets the depth.
// Reset clears the configuration registers to zero and empties the pipeline.
module gradient_position_mapper_core #(
  parameter int PIXEL_BITS         = gpm_pkg::DEF_PIXEL_BITS,
  parameter int POSITION_FRAC_BITS = gpm_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gpm_in_if.sink                            in_if,
  gpm_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpm_pkg::COORD_W-1:0]       cfg_data
);
  import gpm_pkg::*;

  localparam int F       = POSITION_FRAC_BITS;
  localparam int DW      = dot_w(PIXEL_BITS);
  localparam int RAD_LAT = 3 * F;
  localparam int LAT     = max_i(RAD_LAT, ANG_LAT);
  localparam int PIPE    = 4 + LAT;

  // configuration registers
  gpm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:    cfg_r.kind    <= cfg_data[KIND_W-1:0];
        CFG_START_X: cfg_r.start_x <= cfg_data;
        CFG_START_Y: cfg_r.start_y <= cfg_data;
        CFG_END_X:   cfg_r.end_x   <= cfg_data;
        CFG_END_Y:   cfg_r.end_y   <= cfg_data;
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  // advance everything when the output register is free or being drained
  logic advance;
  logic out_valid_r;
  logic vld_r [PIPE];

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (advance) begin
      vld_r[0] <= in_if.valid;
      for (int i = 1; i < PIPE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // front stages
  gpm_ctl_t             ctl4;
  logic [LEN_W-1:0]     len2;
  logic [LEN_W:0]       rat_num, rad_num;
  logic [1:0]           rat_tag;
  logic                 rad_sat;
  logic signed [DW-1:0] ang_a, ang_b;

  gpm_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk       (clk),
    .en        (advance),
    .pixel_x   (in_if.pixel_x),
    .pixel_y   (in_if.pixel_y),
    .cfg       (cfg_r),
    .ctl_o     (ctl4),
    .len2_o    (len2),
    .rat_num_o (rat_num),
    .rat_tag_o (rat_tag),
    .rad_num_o (rad_num),
    .rad_sat_o (rad_sat),
    .ang_a_o   (ang_a),
    .ang_b_o   (ang_b)
  );

  // ratio lane: linear, reflected, diamond
  logic [F-1:0] rat_q;
  logic [1:0]   rat_tag_q;
  logic [F:0]   rat_pos, rat_pos_d;

  gpm_div #(.STEPS(F), .TAG_W(2)) u_rat_div (
    .clk     (clk),
    .en      (advance),
    .num     (rat_num),
    .den     (len2),
    .tag_in  (rat_tag),
    .quot    (rat_q),
    .tag_out (rat_tag_q)
  );

  always_comb begin
    priority if (rat_tag_q[1]) begin
      rat_pos = {1'b1, {F{1'b0}}};
    end else if (rat_tag_q[0]) begin
      rat_pos = '0;
    end else begin
      rat_pos = {1'b0, rat_q};
    end
  end

  gpm_delay #(.WIDTH(F + 1), .DEPTH(LAT - F)) u_rat_dly (
    .clk (clk), .en (advance), .din (rat_pos), .dout (rat_pos_d)
  );

  // radial lane: fraction of squared lengths, then square root
  logic [2*F-1:0] rad_q;
  logic           rad_sat_q, rad_sat_s;
  logic [F-1:0]   rad_root;
  logic [F:0]     rad_pos, rad_pos_d;

  gpm_div #(.STEPS(2 * F), .TAG_W(1)) u_rad_div (
    .clk     (clk),
    .en      (advance),
    .num     (rad_num),
    .den     (len2),
    .tag_in  (rad_sat),
    .quot    (rad_q),
    .tag_out (rad_sat_q)
  );

  gpm_sqrt #(.ROOT_BITS(F), .TAG_W(1)) u_rad_sqrt (
    .clk      (clk),
    .en       (advance),
    .radicand (rad_q),
    .tag_in   (rad_sat_q),
    .root     (rad_root),
    .tag_out  (rad_sat_s)
  );

  assign rad_pos = rad_sat_s ? {1'b1, {F{1'b0}}} : {1'b0, rad_root};

  gpm_delay #(.WIDTH(F + 1), .DEPTH(LAT - RAD_LAT)) u_rad_dly (
    .clk (clk), .en (advance), .din (rad_pos), .dout (rad_pos_d)
  );

  // angle lane
  logic [TURN_W-1:0] turns;
  logic [F-1:0]      ang_pos, ang_pos_d;

  gpm_cordic #(.IN_W(DW)) u_cordic (
    .clk   (clk),
    .en    (advance),
    .a_in  (ang_a),
    .b_in  (ang_b),
    .turns (turns)
  );

  assign ang_pos = turns[TURN_W-1 -: F];

  gpm_delay #(.WIDTH(F), .DEPTH(LAT - ANG_LAT)) u_ang_dly (
    .clk (clk), .en (advance), .din (ang_pos), .dout (ang_pos_d)
  );

  // control travels alongside the lanes
  gpm_ctl_t ctl_d;

  gpm_delay #(.WIDTH($bits(gpm_ctl_t)), .DEPTH(LAT)) u_ctl_dly (
    .clk (clk), .en (advance), .din (ctl4), .dout (ctl_d)
  );

  // pick the lane for the kind and register the result
  logic [F:0] pos_sel;
  logic [F:0] position_r;
  logic       degenerate_r;

  always_comb begin
    unique case (ctl_d.kind)
      KIND_LINEAR, KIND_REFLECTED, KIND_DIAMOND: pos_sel = rat_pos_d;
      KIND_RADIAL:                               pos_sel = rad_pos_d;
      KIND_ANGLE:                                pos_sel = {1'b0, ang_pos_d};
      default:                                   pos_sel = '0;
    endcase
    if (ctl_d.degenerate) begin
      pos_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      position_r   <= pos_sel;
      degenerate_r <= ctl_d.degenerate;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.position   = position_r;
  assign out_if.degenerate = degenerate_r;

endmodule

>>> sim/tb_top.sv
// Self-checking bench for the gradient position mapper: shaped requests, golden model, scoreboard.
module tb_top;
  import gpm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam int  PIX_MAX   = 4095;
  localparam int  DRAIN_CYC = 60;
  localparam int  HOLD_CYC  = 300;
  localparam longint unsigned POS_ONE = 64'd65536;

  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
  } pixel_req_t;

  typedef struct {
    logic [16:0] position;
    logic        degenerate;
  } grad_pos_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  gpm_in_if  in_bus ();
  gpm_out_if out_bus ();

  gradient_position_mapper_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the gradient setup
  logic [KIND_W-1:0]         g_kind;
  logic signed [COORD_W-1:0] g_sx, g_sy, g_ex, g_ey;

  pixel_req_t pixel_q[$];
  grad_pos_t  pos_q[$];
  int         err_cnt;
  bit         taken;
  int         gap_left, burst_left;
  int         hold_cnt, stall_mode, mode_left;
  bit         hold_req, hold_seen;

  logic [31:0] atan_tab [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // floor(num * 2^bits / den), num < den
  function automatic longint unsigned frac_quot(longint unsigned num, longint unsigned den,
                                                int bits);
    longint unsigned q;
    q = 0;
    for (int i = 0; i < bits; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vector angle in turns, 2^32 per turn, by CORDIC vectoring
  function automatic logic [31:0] vec_turns(longint a, longint b);
    longint lim, ta, tb;
    logic [31:0] z;
    lim = 64'sd1 <<< 59;
    z = '0;
    if (b == 0) return (a >= 0) ? 32'd0 : TURN_HALF;
    if (a == 0) return (b > 0) ? TURN_QUARTER : TURN_3QUARTER;
    if (a < 0) begin
      a = -a;
      b = -b;
      z = TURN_HALF;
    end
    while (a < lim && b < lim && b > -lim) begin
      a = a * 2;
      b = b * 2;
    end
    for (int i = 0; i < 32; i++) begin
      ta = a >>> i;
      tb = b >>> i;
      if (b >= 0) begin
        a = a + tb;
        b = b - ta;
        z = z + atan_tab[i];
      end else begin
        a = a - tb;
        b = b + ta;
        z = z - atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned clamp_ratio(longint num, longint unsigned den);
    if (num <= 0) return 0;
    if (longint'(num) >= longint'(den)) return POS_ONE;
    return frac_quot(num, den, 16);
  endfunction

  function automatic grad_pos_t map_pixel(pixel_req_t r);
    grad_pos_t res;
    longint cx, cy, dx, dy, rx, ry, dot, crs, adot, acrs;
    longint unsigned len2, r2, pos;
    logic [31:0] t;
    cx = longint'({r.px, 4'd8});
    cy = longint'({r.py, 4'd8});
    dx = longint'(g_ex) - longint'(g_sx);
    dy = longint'(g_ey) - longint'(g_sy);
    res.degenerate = 1'b0;
    pos = 0;
    if (dx == 0 && dy == 0) begin
      res.position = '0;
      res.degenerate = 1'b1;
      return res;
    end
    rx = cx - longint'(g_sx);
    ry = cy - longint'(g_sy);
    len2 = dx * dx + dy * dy;
    dot = rx * dx + ry * dy;
    crs = ry * dx - rx * dy;
    adot = (dot < 0) ? -dot : dot;
    acrs = (crs < 0) ? -crs : crs;
    case (g_kind)
      KIND_LINEAR: pos = clamp_ratio(dot, len2);
      KIND_RADIAL: begin
        r2 = rx * rx + ry * ry;
        pos = (r2 >= len2) ? POS_ONE : int_sqrt(frac_quot(r2, len2, 32));
      end
      KIND_ANGLE: begin
        t = (rx == 0 && ry == 0) ? vec_turns(dx, -dy) : vec_turns(dot, crs);
        pos = t >> 16;
      end
      KIND_REFLECTED: pos = clamp_ratio(adot, len2);
      KIND_DIAMOND:   pos = clamp_ratio(adot + acrs, len2);
      default:        pos = 0;
    endcase
    res.position = pos[16:0];
    return res;
  endfunction

  // accept a request: predict its position
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      pos_q.push_back(map_pixel(pixel_q.pop_front()));
      taken <= 1'b1;
    end
  end

  // drive requests in bursts with gaps
  always @(negedge clk) begin
    taken <= 1'b0;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !taken) begin
      // hold the offered request
    end else if (gap_left > 0) begin
      in_bus.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pixel_q.size() > 0) begin
      in_bus.valid   <= 1'b1;
      in_bus.pixel_x <= pixel_q[0].px;
      in_bus.pixel_y <= pixel_q[0].py;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(40, 1);
        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // result ready: stall modes plus two long hold-offs
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_bus.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYC;
      out_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2, 0);
        mode_left <= $urandom_range(64, 8);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(1, 0));
        default: out_bus.ready <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    grad_pos_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pos_q.size() == 0) begin
        $display("%0t: unexpected result position=%0d degenerate=%0b", $time,
                 out_bus.position, out_bus.degenerate);
        err_cnt++;
      end else begin
        want = pos_q.pop_front();
        if (out_bus.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_bus.position);
          err_cnt++;
        end
        if (out_bus.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                   out_bus.degenerate);
          err_cnt++;
        end
      end
    end
  end

  task automatic drain();
    while (pixel_q.size() > 0 || pos_q.size() > 0 || in_bus.valid) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_gradient(logic [KIND_W-1:0] k, int sx, int sy, int ex, int ey);
    logic [COORD_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    vals = '{COORD_W'(k), COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey)};
    idx  = '{CFG_KIND, CFG_START_X, CFG_START_Y, CFG_END_X, CFG_END_Y};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    g_kind = k;
    g_sx = COORD_W'(sx);
    g_sy = COORD_W'(sy);
    g_ex = COORD_W'(ex);
    g_ey = COORD_W'(ey);
  endtask

  task automatic add_pixel(int x, int y);
    pixel_req_t r;
    r.px = 12'(x);
    r.py = 12'(y);
    pixel_q.push_back(r);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3, 0))
      0: return $signed($urandom_range(1048575, 0)) <<< 12 >>> 12;
      1: return ($urandom_range(1, 0) == 0) ? -524288 : 524287;
      default: return int'($urandom_range(70000, 0)) - 2000;
    endcase
  endfunction

  initial begin
    logic [KIND_W-1:0] k;
    int sx, sy, ex, ey, n, cx, cy;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.pixel_x = '0;
    in_bus.pixel_y = '0;
    out_bus.ready = 1'b0;
    err_cnt = 0;
    taken = 1'b0;
    gap_left = 0;
    burst_left = 0;
    hold_cnt = 0;
    stall_mode = 0;
    mode_left = 0;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    g_kind = KIND_LINEAR;
    g_sx = '0;
    g_sy = '0;
    g_ex = '0;
    g_ey = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: start equals end, always degenerate
    add_pixel(0, 0);
    add_pixel(PIX_MAX, PIX_MAX);
    drain();

    // each kind on a diagonal gradient, field extremes and axis points
    for (int kk = 0; kk <= 4; kk++) begin
      set_gradient(KIND_W'(kk), 16 * 100 + 8, 16 * 200 + 8, 16 * 3000, 16 * 2500);
      add_pixel(0, 0);
      add_pixel(PIX_MAX, PIX_MAX);
      add_pixel(0, PIX_MAX);
      add_pixel(PIX_MAX, 0);
      add_pixel(100, 200);  // centre on the start point
      add_pixel(300, 200);
      add_pixel(100, 400);
      add_pixel(50, 200);
      add_pixel(100, 150);
      drain();
    end

    // unused kind code and full-span extremes
    set_gradient(KIND_SPARE_LAST, -524288, 524287, 524287, -524288);
    add_pixel(7, 9);
    drain();
    set_gradient(KIND_RADIAL, -524288, -524288, 524287, 524287);
    add_pixel(0, 0);
    add_pixel(PIX_MAX, PIX_MAX);
    drain();

    // random gradients, random pixels
    for (int ph = 0; ph < 20; ph++) begin
      n = $urandom_range(6, 0);
      k = (n == 6) ? KIND_W'(KIND_SPARE_FIRST + $urandom_range(2, 0)) : KIND_W'(n % 5);
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(7, 0) == 0) begin
        ex = sx;
        ey = sy;
      end else begin
        ex = rand_coord();
        ey = rand_coord();
      end
      set_gradient(k, sx, sy, ex, ey);
      if (ph == 3 || ph == 12) hold_req = ~hold_req;
      cx = (sx >>> 4);
      cy = (sy >>> 4);
      for (int i = 0; i < 57; i++) begin
        if ($urandom_range(3, 0) == 0 && cx >= 0 && cx <= PIX_MAX && cy >= 0 &&
            cy <= PIX_MAX) begin
          add_pixel(cx, $urandom_range(PIX_MAX, 0));
        end else begin
          add_pixel($urandom_range(PIX_MAX, 0), $urandom_range(PIX_MAX, 0));
        end
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
